// ===== rtl/rbd_pkg.sv =====
// ----------------------------------------------------------------------------
// rbd_pkg: shared types and constants for the ring buffer deque
// Sizes, operation and status codes, and the controller command bundle.
// ----------------------------------------------------------------------------
package rbd_pkg;

    // Storage geometry
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Port field widths
    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int OFF_W    = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Widths for offset compare and index arithmetic
    localparam int CMP_W = (OFF_W > CNT_W) ? OFF_W : CNT_W;
    localparam int SUM_W = ((OFF_W > ADDR_W) ? OFF_W : ADDR_W) + 1;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_READ_AT    = 3'd4,
        OP_PEEK_BACK  = 3'd5,
        OP_CLEAR      = 3'd6
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Controller to datapath commands
    typedef struct packed {
        logic exec;     // execute the accepted operation
        logic capture;  // load the store read data into the result
    } t_cmd;

endpackage

// ===== rtl/rbd_if.sv =====
// ----------------------------------------------------------------------------
// rbd_if: handshake channels of the ring buffer deque
// Operation channel and result channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface rbd_in_if;
    logic                        valid;
    logic                        ready;
    logic [rbd_pkg::OP_W-1:0]    operation;
    logic [rbd_pkg::VALUE_W-1:0] push_value;
    logic [rbd_pkg::OFF_W-1:0]   read_offset;

    modport source (output valid, output operation, output push_value,
                    output read_offset, input ready);
    modport sink   (input valid, input operation, input push_value,
                    input read_offset, output ready);
endinterface

interface rbd_out_if;
    logic                         valid;
    logic                         ready;
    logic [rbd_pkg::VALUE_W-1:0]  read_data;
    logic [rbd_pkg::STATUS_W-1:0] status;
    logic [rbd_pkg::COUNT_W-1:0]  count;
    logic                         is_empty;

    modport source (output valid, output read_data, output status,
                    output count, output is_empty, input ready);
    modport sink   (input valid, input read_data, input status,
                    input count, input is_empty, output ready);
endinterface

// ===== rtl/rbd_ram.sv =====
// ----------------------------------------------------------------------------
// rbd_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/rbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbd_ctrl: deque sequencer
// Accepts operations, waits in S_READ on store reads, and owns result valid.
// ----------------------------------------------------------------------------
module rbd_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic [rbd_pkg::OP_W-1:0] i_operation,
    input  logic                     i_out_ready,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    output rbd_pkg::t_cmd            o_cmd
);
    import rbd_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   needs_read;

    // Take a new transaction once the result register is free or draining
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;
    assign needs_read = (t_op'(i_operation) == OP_READ_AT) ||
                        (t_op'(i_operation) == OP_PEEK_BACK);

    assign o_cmd.exec    = accept;
    assign o_cmd.capture = (r_state == S_READ);
    assign o_out_valid   = r_out_valid;

    // Next state and result valid
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        unique case (r_state)
            S_IDLE: begin
                if (r_out_valid && i_out_ready) begin
                    n_out_valid = 1'b0;
                end
                if (accept) begin
                    if (needs_read) begin
                        n_state     = S_READ;
                        n_out_valid = 1'b0;
                    end else begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            S_READ: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

// ===== rtl/rbd_dpath.sv =====
// ----------------------------------------------------------------------------
// rbd_dpath: deque datapath
// Front and back pointers, occupancy count, ring store and result register.
// ----------------------------------------------------------------------------
module rbd_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rbd_pkg::t_cmd                i_cmd,
    input  logic [rbd_pkg::OP_W-1:0]     i_operation,
    input  logic [rbd_pkg::VALUE_W-1:0]  i_push_value,
    input  logic [rbd_pkg::OFF_W-1:0]    i_read_offset,
    output logic [rbd_pkg::VALUE_W-1:0]  o_read_data,
    output logic [rbd_pkg::STATUS_W-1:0] o_status,
    output logic [rbd_pkg::COUNT_W-1:0]  o_count,
    output logic                         o_is_empty
);
    import rbd_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    logic [ADDR_W-1:0]     r_head, n_head;
    logic [ADDR_W-1:0]     r_tail, n_tail;
    logic [CNT_W-1:0]      r_count, n_count;
    t_status               r_status, n_status;
    logic                  r_use_ram, n_use_ram;
    logic [DATA_WIDTH-1:0] r_rd;

    logic                  full;
    logic                  empty;
    logic [ADDR_W-1:0]     head_dec, head_inc, tail_dec, tail_inc;
    logic [SUM_W-1:0]      off_sum;
    logic [ADDR_W-1:0]     off_addr;
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [ADDR_W-1:0]     raddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic [DATA_WIDTH-1:0] ram_q;

    assign full  = (r_count == CNT_W'(DEPTH));
    assign empty = (r_count == '0);

    // Wrap pointers around the ring
    assign head_dec = (r_head == '0)        ? LAST_ADDR : r_head - 1'b1;
    assign head_inc = (r_head == LAST_ADDR) ? '0        : r_head + 1'b1;
    assign tail_dec = (r_tail == '0)        ? LAST_ADDR : r_tail - 1'b1;
    assign tail_inc = (r_tail == LAST_ADDR) ? '0        : r_tail + 1'b1;

    // Front-relative index; below twice the depth when in range
    assign off_sum  = SUM_W'(r_head) + SUM_W'(i_read_offset);
    assign off_addr = (off_sum >= SUM_W'(DEPTH)) ? ADDR_W'(off_sum - SUM_W'(DEPTH))
                                                 : ADDR_W'(off_sum);

    assign wdata = DATA_WIDTH'(i_push_value);

    // Decode the operation against the current pointers
    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_status  = ST_OK;
        n_use_ram = 1'b0;
        we        = 1'b0;
        waddr     = head_dec;
        raddr     = off_addr;
        unique case (t_op'(i_operation))
            OP_PUSH_FRONT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_head  = head_dec;
                    n_count = r_count + 1'b1;
                    we      = 1'b1;
                    waddr   = head_dec;
                end
            end
            OP_PUSH_BACK: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_tail  = tail_inc;
                    n_count = r_count + 1'b1;
                    we      = 1'b1;
                    waddr   = tail_inc;
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_head  = head_inc;
                    n_count = r_count - 1'b1;
                end
            end
            OP_POP_BACK: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_tail  = tail_dec;
                    n_count = r_count - 1'b1;
                end
            end
            OP_READ_AT: begin
                if (CMP_W'(i_read_offset) >= CMP_W'(r_count)) begin
                    n_status = ST_RANGE;
                end else begin
                    n_use_ram = 1'b1;
                    raddr     = off_addr;
                end
            end
            OP_PEEK_BACK: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_use_ram = 1'b1;
                    raddr     = r_tail;
                end
            end
            OP_CLEAR: begin
                n_head  = '0;
                n_tail  = LAST_ADDR;
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    rbd_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we && i_cmd.exec),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    // Advance pointers and count on each executed transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= LAST_ADDR;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Hold result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status  <= n_status;
            r_use_ram <= n_use_ram;
            r_rd      <= '0;
        end else if (i_cmd.capture) begin
            r_rd <= r_use_ram ? ram_q : '0;
        end
    end

    assign o_read_data = VALUE_W'(r_rd);
    assign o_status    = r_status;
    assign o_count     = COUNT_W'(r_count);
    assign o_is_empty  = empty;
endmodule

// ===== rtl/ring_buffer_deque.sv =====
// ----------------------------------------------------------------------------
// ring_buffer_deque: fixed-depth double-ended queue in a ring store
// Push and pop at either end, read by offset, peek back, clear; one result
// per operation with read data, status, count and empty flag.
//
//   channel  dir  signals                                  carries
//   i_in     in   valid ready operation push_value         one operation
//                 read_offset
//   o_out    out  valid ready read_data status count       one result
//                 is_empty
//
// Push, pop, clear and unused codes give their result in the cycle after
// acceptance; read at offset and peek back wait in S_READ for the registered
// read port of the ring store. One operation is in flight at a time.
// Reset is synchronous, active low; pointers and count clear, store contents
// are left as they are, and no clearing pass is needed.
// A new transaction is taken while the previous result is being taken.
// ----------------------------------------------------------------------------
module ring_buffer_deque (
    input  logic i_clk,
    input  logic i_rst_n,
    rbd_in_if.sink    i_in,
    rbd_out_if.source o_out
);
    import rbd_pkg::*;

    t_cmd cmd;

    rbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_operation (i_in.operation),
        .i_out_ready (o_out.ready),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    rbd_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_operation   (i_in.operation),
        .i_push_value  (i_in.push_value),
        .i_read_offset (i_in.read_offset),
        .o_read_data   (o_out.read_data),
        .o_status      (o_out.status),
        .o_count       (o_out.count),
        .o_is_empty    (o_out.is_empty)
    );
endmodule
